// ===== hdl/salu_pkg.sv =====
// Shared types, codes and helpers for the saturating integer ALU.
package salu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned LimbW = DataW / 2;

  // Operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;

  // Element width codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic             is_signed;
    logic [1:0]       width_sel;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } salu_in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             saturated;
  } salu_out_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic             mul;     // multiply item, final result picked in last stage
    logic             sgn;     // signed element type
    logic [1:0]       wsel;    // element width code
    logic             neg;     // product is negative and nonzero
    logic             asat;    // add/sub saturated
    logic [DataW-1:0] ar;      // add/sub result, masked to element width
  } salu_ctl_t;

  typedef struct packed {
    salu_ctl_t        ctl;
    logic [DataW-1:0] ma;      // operand magnitudes for the multiplier
    logic [DataW-1:0] mb;
  } salu_s1_t;

  typedef struct packed {
    salu_ctl_t        ctl;
    logic [DataW-1:0] p00;
    logic [DataW-1:0] p01;
    logic [DataW-1:0] p10;
    logic [DataW-1:0] p11;
  } salu_s2_t;

  typedef struct packed {
    salu_ctl_t        ctl;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
  } salu_s3_t;

  // All-ones mask over the selected element width
  function automatic logic [DataW-1:0] width_mask(input logic [1:0] wsel);
    logic [DataW-1:0] m;
    case (wsel)
      WSEL_8:  m = 64'h0000_0000_0000_00FF;
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      WSEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/salu_prep.sv =====
// Stage 1: operand masking, add/sub with saturation, multiplier operand magnitudes.
module salu_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_valid,
  input  salu_pkg::salu_in_t i_data,
  output logic              o_valid,
  output salu_pkg::salu_s1_t o_data
);

  logic                       valid_r;
  salu_pkg::salu_s1_t         data_r;
  salu_pkg::salu_s1_t         data_nxt;

  logic [salu_pkg::DataW-1:0] mask;
  logic [salu_pkg::DataW-1:0] smax;
  logic [salu_pkg::DataW-1:0] sbit;
  logic [salu_pkg::DataW-1:0] a;
  logic [salu_pkg::DataW-1:0] b;
  logic [salu_pkg::DataW:0]   sum;
  logic [salu_pkg::DataW-1:0] r;
  logic                       na;
  logic                       nb;
  logic                       nr;
  logic                       sub;
  logic                       ovf;
  logic                       sgn;

  // Operand decode
  always_comb begin
    mask = salu_pkg::width_mask(i_data.width_sel);
    smax = mask >> 1;
    sbit = mask ^ smax;
    a    = i_data.operand_a & mask;
    b    = i_data.operand_b & mask;
    sgn  = i_data.is_signed;
    na   = |(a & sbit);
    nb   = |(b & sbit);
    sub  = (i_data.command == salu_pkg::CMD_SUB);
    sum  = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
    r    = sum[salu_pkg::DataW-1:0] & mask;
    nr   = |(r & sbit);
    ovf  = sub ? ((na != nb) && (nr != na)) : ((na == nb) && (nr != na));
  end

  // Add/sub result and multiplier setup
  always_comb begin
    data_nxt.ctl.mul  = (i_data.command == salu_pkg::CMD_MUL);
    data_nxt.ctl.sgn  = sgn;
    data_nxt.ctl.wsel = i_data.width_sel;
    data_nxt.ctl.neg  = sgn && (na != nb) && (|a) && (|b);
    data_nxt.ctl.ar   = '0;
    data_nxt.ctl.asat = 1'b0;
    data_nxt.ma       = (sgn && na) ? ((~a + 64'd1) & mask) : a;
    data_nxt.mb       = (sgn && nb) ? ((~b + 64'd1) & mask) : b;
    case (i_data.command)
      salu_pkg::CMD_ADD, salu_pkg::CMD_SUB: begin
        if (sgn) begin
          data_nxt.ctl.asat = ovf;
          data_nxt.ctl.ar   = ovf ? (na ? sbit : smax) : r;
        end else if (sub) begin
          // borrow out means the true difference is below zero
          data_nxt.ctl.asat = sum[salu_pkg::DataW];
          data_nxt.ctl.ar   = sum[salu_pkg::DataW] ? '0 : r;
        end else begin
          // any sum bit above the element width is a carry out
          data_nxt.ctl.asat = |(sum & ~{1'b0, mask});
          data_nxt.ctl.ar   = data_nxt.ctl.asat ? mask : r;
        end
      end
      default: begin
        data_nxt.ctl.ar   = '0;
        data_nxt.ctl.asat = 1'b0;
      end
    endcase
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== hdl/salu_pp.sv =====
// Stage 2: four 32x32 partial products of the operand magnitudes.
module salu_pp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_valid,
  input  salu_pkg::salu_s1_t i_data,
  output logic              o_valid,
  output salu_pkg::salu_s2_t o_data
);

  logic                       valid_r;
  salu_pkg::salu_s2_t         data_r;
  salu_pkg::salu_s2_t         data_nxt;

  logic [salu_pkg::LimbW-1:0] a0;
  logic [salu_pkg::LimbW-1:0] a1;
  logic [salu_pkg::LimbW-1:0] b0;
  logic [salu_pkg::LimbW-1:0] b1;

  // Limb split and products
  always_comb begin
    a0 = i_data.ma[salu_pkg::LimbW-1:0];
    a1 = i_data.ma[salu_pkg::DataW-1:salu_pkg::LimbW];
    b0 = i_data.mb[salu_pkg::LimbW-1:0];
    b1 = i_data.mb[salu_pkg::DataW-1:salu_pkg::LimbW];
    data_nxt.ctl = i_data.ctl;
    data_nxt.p00 = a0 * b0;
    data_nxt.p01 = a0 * b1;
    data_nxt.p10 = a1 * b0;
    data_nxt.p11 = a1 * b1;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== hdl/salu_acc.sv =====
// Stage 3: partial product accumulation into a 128-bit product.
module salu_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              i_valid,
  input  salu_pkg::salu_s2_t i_data,
  output logic              o_valid,
  output salu_pkg::salu_s3_t o_data
);

  localparam int unsigned LW = salu_pkg::LimbW;
  localparam int unsigned DW = salu_pkg::DataW;

  logic               valid_r;
  salu_pkg::salu_s3_t data_r;
  salu_pkg::salu_s3_t data_nxt;
  logic [LW+1:0]      mid;

  // Middle column collects the cross terms and the carry from the low limb
  always_comb begin
    mid = {2'b00, i_data.p00[DW-1:LW]} + {2'b00, i_data.p01[LW-1:0]}
        + {2'b00, i_data.p10[LW-1:0]};
    data_nxt.ctl = i_data.ctl;
    data_nxt.lo  = {mid[LW-1:0], i_data.p00[LW-1:0]};
    data_nxt.hi  = i_data.p11
                 + {{LW{1'b0}}, i_data.p01[DW-1:LW]}
                 + {{LW{1'b0}}, i_data.p10[DW-1:LW]}
                 + {{(DW-2){1'b0}}, mid[LW+1:LW]};
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== hdl/salu_sat.sv =====
// Stage 4: product clamping, result select and sign/zero extension; output register.
module salu_sat (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               i_valid,
  input  salu_pkg::salu_s3_t  i_data,
  output logic               o_valid,
  output salu_pkg::salu_out_t o_data
);

  logic                       valid_r;
  salu_pkg::salu_out_t        data_r;
  salu_pkg::salu_out_t        data_nxt;

  logic [salu_pkg::DataW-1:0] mask;
  logic [salu_pkg::DataW-1:0] smax;
  logic [salu_pkg::DataW-1:0] sbit;
  logic [salu_pkg::DataW-1:0] lim;
  logic [salu_pkg::DataW-1:0] mag;
  logic [salu_pkg::DataW-1:0] r;
  logic                       over;

  // Clamp the product, else take the add/sub result
  always_comb begin
    mask = salu_pkg::width_mask(i_data.ctl.wsel);
    smax = mask >> 1;
    sbit = mask ^ smax;
    // limit is also the clamped value
    lim  = i_data.ctl.sgn ? (i_data.ctl.neg ? sbit : smax) : mask;
    over = (|i_data.hi) || (i_data.lo > lim);
    mag  = i_data.ctl.neg ? (~i_data.lo + 64'd1) : i_data.lo;
    if (i_data.ctl.mul) begin
      r                  = over ? lim : (mag & mask);
      data_nxt.saturated = over;
    end else begin
      r                  = i_data.ctl.ar;
      data_nxt.saturated = i_data.ctl.asat;
    end
    // widen to 64 bits
    if (i_data.ctl.sgn && (|(r & sbit))) begin
      data_nxt.result = r | ~mask;
    end else begin
      data_nxt.result = r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule

// ===== hdl/saturating_int_alu_unit.sv =====
// Saturating integer add/subtract/multiply unit: top level and stage flow control.
//
// One operation per transfer; a new item can be taken every cycle while the output side
// does not stall. The unit is a four-stage pipeline (operand prep and add/sub, 32x32
// partial products, product accumulation, clamp and output register). The first stage
// register loads at the input transfer edge; the item then passes through the product
// and accumulation registers to the output register, where out_valid rises. Each stage
// holds its own valid bit and advances whenever it is empty or the stage after it
// advances, so empty slots are squeezed out under backpressure and the input keeps
// taking items while a finished result waits at the output, until every stage is full.
// Command 3 returns zero, unsaturated. The unit keeps no state between items.
module saturating_int_alu_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  salu_pkg::salu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output salu_pkg::salu_out_t out_data
);

  logic               v1;
  logic               v2;
  logic               v3;
  logic               en1;
  logic               en2;
  logic               en3;
  logic               en4;
  salu_pkg::salu_s1_t s1;
  salu_pkg::salu_s2_t s2;
  salu_pkg::salu_s3_t s3;

  // Stage enables: advance when empty or when the next stage advances
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  salu_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en1),
    .i_valid (in_valid),
    .i_data  (in_data),
    .o_valid (v1),
    .o_data  (s1)
  );

  salu_pp u_pp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .i_valid (v1),
    .i_data  (s1),
    .o_valid (v2),
    .o_data  (s2)
  );

  salu_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .i_valid (v2),
    .i_data  (s2),
    .o_valid (v3),
    .o_data  (s3)
  );

  salu_sat u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en4),
    .i_valid (v3),
    .i_data  (s3),
    .o_valid (out_valid),
    .o_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // An input transfer always lands in stage 1
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1)
    else $error("input transfer did not reach stage 1");

  // A stalled product stage keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2 && !en3) |=> (v2 && $stable(s2)))
    else $error("stalled stage 2 item changed or was lost");

  // With the output side ready the whole pipe moves
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output was ready");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the saturating integer add/subtract/multiply unit.
module tb_top;
  import salu_pkg::*;

  // Command value with no operation behind it
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  salu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  salu_out_t out_data;

  int unsigned in_idle_pct = 9;
  int unsigned out_stall_pct = 74;
  int unsigned err_count = 0;
  int unsigned result_idx = 0;
  int unsigned cycle_count = 0;
  salu_out_t   expected_clamped[$];
  salu_out_t   exp_res;

  saturating_int_alu_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ones over the selected element width
  function automatic logic [63:0] elem_mask(input logic [1:0] wsel);
    if (wsel == WSEL_64) begin
      return '1;
    end
    return (64'd1 << (8 << wsel)) - 64'd1;
  endfunction

  // Exact result clamped to the element type, extended to 64 bits
  function automatic salu_out_t predict_clamped(input salu_in_t op);
    logic [63:0]  mask, smax, sbit, a, b, r, ma, mb, lim;
    logic [127:0] prod;
    logic         sat, na, nb, nr, ovf, neg, sub;
    salu_out_t    res;
    mask = elem_mask(op.width_sel);
    smax = mask >> 1;
    sbit = smax + 64'd1;
    a = op.operand_a & mask;
    b = op.operand_b & mask;
    na = |(a & sbit);
    nb = |(b & sbit);
    r = '0;
    sat = 1'b0;
    case (op.command)
      CMD_ADD, CMD_SUB: begin
        sub = (op.command == CMD_SUB);
        r = (sub ? a - b : a + b) & mask;
        nr = |(r & sbit);
        if (op.is_signed) begin
          // overflow clamps toward the sign of operand a
          ovf = sub ? (na != nb && nr != na) : (na == nb && nr != na);
          if (ovf) begin
            sat = 1'b1;
            r = na ? sbit : smax;
          end
        end else if (sub) begin
          if (a < b) begin
            sat = 1'b1;
            r = '0;
          end
        end else if (r < a) begin
          sat = 1'b1;
          r = mask;
        end
      end
      CMD_MUL: begin
        if (op.is_signed) begin
          ma = na ? ((~a + 64'd1) & mask) : a;
          mb = nb ? ((~b + 64'd1) & mask) : b;
          prod = {64'd0, ma} * {64'd0, mb};
          neg = (na != nb) && (prod != '0);
          lim = neg ? sbit : smax;
          if (prod > {64'd0, lim}) begin
            sat = 1'b1;
            r = lim;
          end else begin
            r = (neg ? (~prod[63:0] + 64'd1) : prod[63:0]) & mask;
          end
        end else begin
          prod = {64'd0, a} * {64'd0, b};
          if (prod > {64'd0, mask}) begin
            sat = 1'b1;
            r = mask;
          end else begin
            r = prod[63:0];
          end
        end
      end
      default: begin
        r = '0;
        sat = 1'b0;
      end
    endcase
    r &= mask;
    if (op.is_signed && |(r & sbit)) begin
      r |= ~mask;
    end
    res.result = r;
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch: %s", msg);
    err_count++;
  endtask

  // One input transfer, with a random gap ahead of it
  task automatic send_op(input logic [1:0] cmd, input logic sgn, input logic [1:0] wsel,
                         input logic [63:0] a, input logic [63:0] b);
    salu_in_t op;
    op.command = cmd;
    op.is_signed = sgn;
    op.width_sel = wsel;
    op.operand_a = a;
    op.operand_b = b;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_data <= op;
    in_valid <= 1'b1;
    expected_clamped.push_back(predict_clamped(op));
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the input off until every result is back
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_clamped.size() != 0);
  endtask

  // Random operand: boundaries, small magnitudes for products in range, junk above width
  function automatic logic [63:0] rand_operand(input logic [1:0] wsel);
    logic [63:0] mask, noise, v;
    int unsigned w;
    mask = elem_mask(wsel);
    w = 8 << wsel;
    noise = {$urandom, $urandom};
    case ($urandom_range(4))
      1: begin
        case ($urandom_range(5))
          0: v = '0;
          1: v = 64'd1;
          2: v = mask;
          3: v = mask >> 1;
          4: v = (mask >> 1) + 64'd1;
          default: v = mask - 64'd1;
        endcase
      end
      2: v = noise >> (64 - w / 2 + $urandom_range(w / 2 - 1));
      3: v = ~(noise >> (64 - w / 2 + $urandom_range(w / 2 - 1))) + 64'd1;
      default: v = noise;
    endcase
    return (v & mask) | ({$urandom, $urandom} & ~mask);
  endfunction

  // Add: clamps at both ends, sign extension, upper bits ignored
  task automatic test_add_limits;
    send_op(CMD_ADD, 1'b0, WSEL_8,  64'hFF, 64'h01);
    send_op(CMD_ADD, 1'b1, WSEL_8,  64'h7F, 64'h01);
    send_op(CMD_ADD, 1'b1, WSEL_8,  64'h80, 64'hFF);
    send_op(CMD_ADD, 1'b0, WSEL_64, '1, '1);
    send_op(CMD_ADD, 1'b1, WSEL_64, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(CMD_ADD, 1'b1, WSEL_16, 64'hDEAD_BEEF_0000_1234, 64'hCAFE_F00D_5555_0001);
    send_op(CMD_ADD, 1'b1, WSEL_32, 64'h0000_0000_FFFF_FFF0, 64'h0000_0000_0000_0005);
  endtask

  // Subtract: unsigned floor at zero, exact zero unsaturated, signed clamps
  task automatic test_sub_limits;
    send_op(CMD_SUB, 1'b0, WSEL_8,  64'h00, 64'h01);
    send_op(CMD_SUB, 1'b0, WSEL_16, 64'h1234, 64'h1234);
    send_op(CMD_SUB, 1'b1, WSEL_8,  64'h80, 64'h01);
    send_op(CMD_SUB, 1'b1, WSEL_32, 64'h7FFF_FFFF, 64'hFFFF_FFFF);
    send_op(CMD_SUB, 1'b1, WSEL_64, 64'h8000_0000_0000_0000, 64'h1);
    send_op(CMD_SUB, 1'b0, WSEL_64, '0, '1);
  endtask

  // Multiply: most negative value, exact limits, full-width products
  task automatic test_mul_limits;
    send_op(CMD_MUL, 1'b1, WSEL_8,  64'h80, 64'hFF);
    send_op(CMD_MUL, 1'b1, WSEL_8,  64'h80, 64'h01);
    send_op(CMD_MUL, 1'b1, WSEL_8,  64'hFF, 64'hFF);
    send_op(CMD_MUL, 1'b0, WSEL_8,  64'hFF, 64'hFF);
    send_op(CMD_MUL, 1'b0, WSEL_32, 64'hFFFF, 64'h1_0001);
    send_op(CMD_MUL, 1'b1, WSEL_16, 64'h0, 64'h8000);
    send_op(CMD_MUL, 1'b1, WSEL_64, 64'h8000_0000_0000_0000, '1);
    send_op(CMD_MUL, 1'b0, WSEL_64, '1, '1);
    send_op(CMD_MUL, 1'b1, WSEL_32, 64'hFFFF_FFFE, 64'h4000_0000);
    send_op(CMD_MUL, 1'b1, WSEL_32, 64'h2, 64'h4000_0000);
  endtask

  // Unused command gives zero, unsaturated
  task automatic test_unused_command;
    send_op(CMD_SPARE, 1'b1, WSEL_64, 64'h8000_0000_0000_0000, '1);
    send_op(CMD_SPARE, 1'b0, WSEL_8,  '1, 64'h1);
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [1:0] cmd, wsel;
    repeat (count) begin
      case ($urandom_range(15))
        0: cmd = CMD_SPARE;
        1, 2, 3, 4, 5: cmd = CMD_ADD;
        6, 7, 8, 9, 10: cmd = CMD_SUB;
        default: cmd = CMD_MUL;
      endcase
      wsel = 2'($urandom_range(3));
      send_op(cmd, 1'($urandom_range(1)), wsel, rand_operand(wsel), rand_operand(wsel));
    end
  endtask

  // Result side stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_clamped.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: %h/%b",
                                  result_idx, out_data.result, out_data.saturated));
      end else begin
        exp_res = expected_clamped.pop_front();
        if (out_data.result !== exp_res.result) begin
          report_mismatch($sformatf("result %0d value %h, expected %h",
                                    result_idx, out_data.result, exp_res.result));
        end
        if (out_data.saturated !== exp_res.saturated) begin
          report_mismatch($sformatf("result %0d saturated %b, expected %b",
                                    result_idx, out_data.saturated, exp_res.saturated));
        end
      end
      result_idx++;
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: timeout after %0d cycles", cycle_count);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    in_idle_pct = 9;
    out_stall_pct = 74;
    test_add_limits;
    test_sub_limits;
    test_mul_limits;
    test_unused_command;
    test_random_mix(250);
    drain_results;

    // sender mostly idle, receiver mostly ready
    in_idle_pct = 74;
    out_stall_pct = 9;
    test_random_mix(250);
    drain_results;

    // full rate both sides
    in_idle_pct = 0;
    out_stall_pct = 0;
    test_random_mix(250);
    drain_results;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_clamped.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
